// ----- design/rpp_pkg.sv -----
`default_nettype none
package rpp_pkg;

    // Fixed formats
    localparam int FRAC_BITS  = 12;
    localparam int COORD_W    = 16;
    localparam int SINE_DEPTH = 256;
    localparam int SINE_IDX_W = 8;
    localparam int TRIG_W     = 16;
    localparam int TRIG_SHIFT = 14;
    localparam int PHASE_W    = 16;
    localparam int OFFS_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 32;
    localparam int R_W        = 20;
    localparam int NUM_W      = 31;
    localparam int DEN_W      = 31;
    localparam int DVD_W      = 44;
    localparam int Q_W        = 45;
    localparam int CNT_W      = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_W_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_OFFSET   = 2'd2;

    typedef enum logic [1:0] {
        FAULT_OK    = 2'd0,
        FAULT_DENOM = 2'd1,
        FAULT_SAT   = 2'd2
    } fault_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TRIG,
        B_MAC,
        B_OFFS,
        B_DIV_GO,
        B_DIV_WAIT,
        B_ZCHK,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0]        phase;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] w;
    } rpp_item_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] quo;
    } div_rsp_t;

    typedef logic signed [TRIG_W-1:0] sine_rom_t [SINE_DEPTH];

    // sin(pi/2*u), u and result in Q30
    function automatic logic [63:0] quarter_sine(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] r;
        u2 = (u * u) >> 30;
        r  = 64'd172272;
        r  = 64'd5026995 - ((u2 * r) >> 30);
        r  = 64'd85569306 - ((u2 * r) >> 30);
        r  = 64'd693598668 - ((u2 * r) >> 30);
        r  = 64'd1686629713 - ((u2 * r) >> 30);
        return (u * r) >> 30;
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t   t;
        logic [63:0] four;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] u;
        logic [63:0] s;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            four = 64'(k) * 64'd4;
            quad = four / SINE_DEPTH;
            rem  = four - quad * SINE_DEPTH;
            if (quad[0])
                rem = 64'(SINE_DEPTH) - rem;
            u = (rem << 30) / SINE_DEPTH;
            s = (quarter_sine(u) + 64'd32768) >> 16;
            if (s > 64'd16384)
                s = 64'd16384;
            t[k] = (quad >= 64'd2) ? -$signed(s[TRIG_W-1:0]) : $signed(s[TRIG_W-1:0]);
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    // Drop TRIG_SHIFT bits, round to nearest, ties away from zero
    function automatic logic signed [R_W-1:0] round_trig(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] m;
        logic [R_W-1:0]   mt;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        m   = (mag + (ACC_W'(1) << (TRIG_SHIFT - 1))) >> TRIG_SHIFT;
        mt  = m[R_W-1:0];
        return v[ACC_W-1] ? $signed(-mt) : $signed(mt);
    endfunction

endpackage
`default_nettype wire

// ----- design/rpp_front.sv -----
`default_nettype none
module rpp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          action,
    input  wire logic signed [rpp_pkg::COORD_W-1:0] px,
    input  wire logic signed [rpp_pkg::COORD_W-1:0] py,
    input  wire logic signed [rpp_pkg::COORD_W-1:0] pz,
    input  wire logic signed [rpp_pkg::COORD_W-1:0] pw,
    input  wire logic [rpp_pkg::PHASE_W-1:0]   angle_step,
    input  wire logic                          q_full,
    output logic                               push,
    output rpp_pkg::rpp_item_t                 push_item
);
    import rpp_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && !action;

    // Point transactions carry the phase they were accepted under
    assign push_item = '{phase: phase_reg, x: px, y: py, z: pz, w: pw};

    // Tick transactions step the phase backward, wrapping at one turn
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && action)
            phase_next = phase_reg - angle_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

endmodule
`default_nettype wire

// ----- design/rpp_fifo.sv -----
`default_nettype none
module rpp_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  rpp_pkg::rpp_item_t      push_item,
    input  wire logic               pop,
    output logic                    full,
    output logic                    empty,
    output rpp_pkg::rpp_item_t      head
);
    import rpp_pkg::*;

    rpp_item_t  mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// ----- design/rpp_div.sv -----
`default_nettype none
module rpp_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  rpp_pkg::div_req_t  req,
    output rpp_pkg::div_rsp_t  rsp
);
    import rpp_pkg::*;

    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] dvd_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             neg_reg;
    logic             neg_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   shifted;
    logic             ge;
    logic [DEN_W:0]   diff;

    assign mag     = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});

    // Restoring division, one quotient bit per cycle; dividend carries the rounding bias
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next  = (DVD_W'(mag) << FRAC_BITS) + DVD_W'(req.den >> 1);
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = '0;
            neg_next  = req.num[NUM_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

endmodule
`default_nettype wire

// ----- design/rpp_back.sv -----
`default_nettype none
module rpp_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_empty,
    input  rpp_pkg::rpp_item_t                      head,
    output logic                                    pop,
    input  wire logic [rpp_pkg::OFFS_W-1:0]         w_offset,
    input  wire logic [rpp_pkg::OFFS_W-1:0]         z_offset,
    output rpp_pkg::div_req_t                       div_req,
    input  rpp_pkg::div_rsp_t                       div_rsp,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [rpp_pkg::COORD_W-1:0]      screen_x,
    output logic signed [rpp_pkg::COORD_W-1:0]      screen_y,
    output logic [1:0]                              fault
);
    import rpp_pkg::*;

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

    back_state_t               state_reg, state_next;
    rpp_item_t                 item_reg, item_next;
    logic signed [TRIG_W-1:0]  s_reg, s_next;
    logic signed [TRIG_W-1:0]  c_reg, c_next;
    logic [2:0]                k_reg, k_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [R_W-1:0]     r_reg [4];
    logic signed [R_W-1:0]     r_next [4];
    logic [2:0]                dsel_reg, dsel_next;
    logic signed [NUM_W-1:0]   x1_reg, x1_next;
    logic signed [NUM_W-1:0]   y1_reg, y1_next;
    logic signed [NUM_W-1:0]   z1_reg, z1_next;
    logic signed [COORD_W-1:0] sx_reg, sx_next;
    logic signed [COORD_W-1:0] sy_reg, sy_next;
    fault_t                    flt_reg, flt_next;
    logic                      sat_reg, sat_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] out_x_reg, out_x_next;
    logic signed [COORD_W-1:0] out_y_reg, out_y_next;
    fault_t                    out_flt_reg, out_flt_next;

    logic [PHASE_W-1:0]        cos_phase;
    logic signed [TRIG_W-1:0]  coef;
    logic signed [COORD_W-1:0] coord;
    logic signed [ACC_W-1:0]   prod;
    logic signed [R_W-1:0]     rw_sum;
    logic                      out_free;
    logic                      q_sat;
    logic signed [COORD_W-1:0] q_clamp;

    // Multiply-accumulate operand select: eight products, four rotated sums
    assign coef  = (k_reg[0] ^ k_reg[1]) ? s_reg : c_reg;
    assign coord = k_reg[2] ? (k_reg[0] ? item_reg.w : item_reg.y)
                            : (k_reg[0] ? item_reg.z : item_reg.x);
    assign prod  = ACC_W'(coef) * ACC_W'(coord);

    assign cos_phase = item_reg.phase + PHASE_W'(1 << (PHASE_W - 2));
    assign rw_sum    = r_reg[3] + R_W'(w_offset);
    assign out_free  = !out_valid_reg || out_ready;

    // Final quotient clamp
    assign q_sat   = (div_rsp.quo > Q_MAX) || (div_rsp.quo < Q_MIN);
    assign q_clamp = (div_rsp.quo > Q_MAX) ? Q_MAX[COORD_W-1:0] :
                     (div_rsp.quo < Q_MIN) ? Q_MIN[COORD_W-1:0] : div_rsp.quo[COORD_W-1:0];

    assign out_valid = out_valid_reg;
    assign screen_x  = out_x_reg;
    assign screen_y  = out_y_reg;
    assign fault     = out_flt_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:     if (!q_empty) state_next = B_TRIG;
            B_TRIG:     state_next = B_MAC;
            B_MAC:      if (k_reg == 3'd7) state_next = B_OFFS;
            B_OFFS:     state_next = (rw_sum <= 0) ? B_OUT : B_DIV_GO;
            B_DIV_GO:   state_next = B_DIV_WAIT;
            B_DIV_WAIT:
                if (div_rsp.done)
                begin
                    if (dsel_reg == 3'd2)
                        state_next = B_ZCHK;
                    else if (dsel_reg == 3'd4)
                        state_next = B_OUT;
                    else
                        state_next = B_DIV_GO;
                end
            B_ZCHK:     state_next = (z1_reg <= 0) ? B_OUT : B_DIV_GO;
            B_OUT:      if (out_free) state_next = B_IDLE;
            default:    state_next = B_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        item_next      = item_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        dsel_next      = dsel_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        z1_next        = z1_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        flt_next       = flt_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_flt_next   = out_flt_reg;
        pop            = 1'b0;
        div_req        = '{start: 1'b0, num: '0, den: '0};
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    item_next = head;
                    sat_next  = 1'b0;
                end
            B_TRIG:
            begin
                s_next = SINE_ROM[item_reg.phase[PHASE_W-1 -: SINE_IDX_W]];
                c_next = SINE_ROM[cos_phase[PHASE_W-1 -: SINE_IDX_W]];
                k_next = 3'd0;
            end
            B_MAC:
            begin
                if (k_reg[0] && !k_reg[1])
                    acc_next = acc_reg - prod;
                else if (k_reg[0])
                    acc_next = acc_reg + prod;
                else
                    acc_next = prod;
                if (k_reg[0])
                    r_next[k_reg[2:1]] = round_trig(acc_next);
                k_next = k_reg + 3'd1;
            end
            B_OFFS:
            begin
                r_next[3] = rw_sum;
                dsel_next = 3'd0;
                if (rw_sum <= 0)
                begin
                    sx_next  = '0;
                    sy_next  = '0;
                    flt_next = FAULT_DENOM;
                end
            end
            B_DIV_GO:
            begin
                div_req.start = 1'b1;
                case (dsel_reg)
                    3'd0:    div_req.num = NUM_W'(r_reg[0]);
                    3'd1:    div_req.num = NUM_W'(r_reg[2]);
                    3'd2:    div_req.num = NUM_W'(r_reg[1]);
                    3'd3:    div_req.num = x1_reg;
                    default: div_req.num = y1_reg;
                endcase
                div_req.den = (dsel_reg < 3'd3) ? DEN_W'(r_reg[3][R_W-2:0])
                                                : z1_reg[DEN_W-1:0];
            end
            B_DIV_WAIT:
                if (div_rsp.done)
                begin
                    case (dsel_reg)
                        3'd0:    x1_next = div_rsp.quo[NUM_W-1:0];
                        3'd1:    y1_next = div_rsp.quo[NUM_W-1:0];
                        3'd2:    z1_next = div_rsp.quo[NUM_W-1:0] + NUM_W'(z_offset);
                        3'd3:
                        begin
                            sx_next  = q_clamp;
                            sat_next = sat_reg || q_sat;
                        end
                        default:
                        begin
                            sy_next  = q_clamp;
                            sat_next = sat_reg || q_sat;
                            flt_next = (sat_reg || q_sat) ? FAULT_SAT : FAULT_OK;
                        end
                    endcase
                    dsel_next = dsel_reg + 3'd1;
                end
            B_ZCHK:
                if (z1_reg <= 0)
                begin
                    sx_next  = '0;
                    sy_next  = '0;
                    flt_next = FAULT_DENOM;
                end
            B_OUT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = sx_reg;
                    out_y_next     = sy_reg;
                    out_flt_next   = flt_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        s_reg       <= s_next;
        c_reg       <= c_next;
        k_reg       <= k_next;
        acc_reg     <= acc_next;
        r_reg       <= r_next;
        dsel_reg    <= dsel_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        z1_reg      <= z1_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        flt_reg     <= flt_next;
        sat_reg     <= sat_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_flt_reg <= out_flt_next;
    end

endmodule
`default_nettype wire

// ----- design/rotate_project_4d_point.sv -----
// 4D vertex rotation (xz and yw planes) followed by two perspective divides.
// Input channel in_valid/in_ready carries action, px, py, pz, pw (signed Q3.12).
// action 1 is a tick: angle phase steps back by angle_step, no result.
// action 0 is a point: one result transaction on out_valid/out_ready with
// screen_x, screen_y (signed Q3.12) and fault (0 ok, 1 bad denominator,
// 2 saturated).
// Config: cfg_we writes cfg_data to register cfg_index (0 angle_step,
// 1 w_offset, 2 z_offset) in the same cycle; write only while idle.
// Front end takes points into a two-entry queue and keeps the phase;
// each point carries the phase it arrived under. Back end runs the math.
// The back end takes a new point only when it is through with the last one;
// the 44-step serial divider runs five times per point (plus trig lookup and
// an 8-step multiply pass).
// A point rejected at the first denominator skips the divider.
// Ticks are accepted whenever the queue has room.
// Reset clears phase to 0, sets registers to 91 / 8192 / 24576, clears queue and out_valid.
// A stalled receiver holds the result register; the back end then waits and
// the queue fills, after which in_ready drops.
`default_nettype none
module rotate_project_4d_point (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 action,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   px,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   py,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   pz,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   pw,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [rpp_pkg::COORD_W-1:0]        screen_x,
    output logic signed [rpp_pkg::COORD_W-1:0]        screen_y,
    output logic [1:0]                                fault,
    input  wire logic                                 cfg_we,
    input  wire logic [rpp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rpp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import rpp_pkg::*;

    logic [PHASE_W-1:0] angle_step_reg, angle_step_next;
    logic [OFFS_W-1:0]  w_offset_reg, w_offset_next;
    logic [OFFS_W-1:0]  z_offset_reg, z_offset_next;
    logic               q_full;
    logic               q_empty;
    logic               push;
    logic               pop;
    rpp_item_t          push_item;
    rpp_item_t          head;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Configuration registers
    always_comb
    begin
        angle_step_next = angle_step_reg;
        w_offset_next   = w_offset_reg;
        z_offset_next   = z_offset_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ANGLE_STEP: angle_step_next = cfg_data[PHASE_W-1:0];
                CFG_W_OFFSET:   w_offset_next   = cfg_data[OFFS_W-1:0];
                CFG_Z_OFFSET:   z_offset_next   = cfg_data[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_step_reg <= PHASE_W'(91);
            w_offset_reg   <= OFFS_W'(8192);
            z_offset_reg   <= OFFS_W'(24576);
        end
        else
        begin
            angle_step_reg <= angle_step_next;
            w_offset_reg   <= w_offset_next;
            z_offset_reg   <= z_offset_next;
        end
    end

    rpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .px         (px),
        .py         (py),
        .pz         (pz),
        .pw         (pw),
        .angle_step (angle_step_reg),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    rpp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    rpp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .w_offset  (w_offset_reg),
        .z_offset  (z_offset_reg),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .fault     (fault)
    );

    // A result always carries a defined fault code
    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fault == FAULT_OK || fault == FAULT_DENOM || fault == FAULT_SAT))
        else $error("undefined fault code on result");

    // A bad denominator returns the origin
    a_denom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault == FAULT_DENOM) |-> (screen_x == '0 && screen_y == '0))
        else $error("denominator fault with nonzero coordinates");

    // Queue never pushed while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("push into full queue");

endmodule
`default_nettype wire

// ----- bench/rpp_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module rpp_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic                                 action,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   px,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   py,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   pz,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   pw,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   screen_x,
    input  wire logic signed [rpp_pkg::COORD_W-1:0]   screen_y,
    input  wire logic [1:0]                           fault,
    input  wire logic                                 cfg_we,
    input  wire logic [rpp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rpp_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                        errors,
    output int                                        pending
);
    import rpp_pkg::*;

    localparam logic ACT_TICK = 1'b1;
    localparam longint MID_SAT = 64'sd549755813887;
    localparam longint OUT_SAT = 64'sd32767;

    typedef struct {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        fault_t                    flt;
    } screen_pt_t;

    screen_pt_t      screen_pts_due[$];
    longint          sine_lut[SINE_DEPTH];
    logic [15:0]     angle_phase;
    logic [15:0]     angle_step;
    logic [14:0]     w_off;
    logic [14:0]     z_off;

    // odd polynomial for sin over a quarter turn, Q30 in and out
    function automatic longint unsigned poly_sine(input longint unsigned u);
        longint unsigned sq;
        longint unsigned acc;
        sq  = (u * u) >> 30;
        acc = 172272;
        acc = 5026995 - ((sq * acc) >> 30);
        acc = 85569306 - ((sq * acc) >> 30);
        acc = 693598668 - ((sq * acc) >> 30);
        acc = 1686629713 - ((sq * acc) >> 30);
        return (u * acc) >> 30;
    endfunction

    initial
    begin
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned mag;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            quad = (k * 4) / SINE_DEPTH;
            rem  = (k * 4) % SINE_DEPTH;
            if (quad % 2 == 1)
                rem = SINE_DEPTH - rem;
            mag = (poly_sine((rem << 30) / SINE_DEPTH) + 32768) >> 16;
            if (mag > 16384)
                mag = 16384;
            sine_lut[k] = (quad >= 2) ? -longint'(mag) : longint'(mag);
        end
    end

    function automatic longint round_q14(input longint v);
        if (v >= 0)
            return (v + 8192) >>> 14;
        return -((-v + 8192) >>> 14);
    endfunction

    // n * 2^12 / d, nearest, ties away from zero; d > 0
    function automatic longint div_frac(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q   = ((mag << FRAC_BITS) + (d >>> 1)) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint sat_to(input longint v, input longint lim, inout bit hit);
        if (v > lim)
        begin
            hit = 1'b1;
            return lim;
        end
        if (v < -lim - 1)
        begin
            hit = 1'b1;
            return -lim - 1;
        end
        return v;
    endfunction

    function automatic screen_pt_t project_point(input longint x, input longint y,
                                                 input longint z, input longint w,
                                                 input logic [15:0] ph);
        screen_pt_t res;
        longint s, c, rx, ry, rz, rw, x1, y1, z1;
        logic [15:0] cph;
        bit hit;
        hit = 1'b0;
        cph = ph + 16'd16384;
        s   = sine_lut[ph[15:8]];
        c   = sine_lut[cph[15:8]];
        rx  = round_q14(c * x - s * z);
        rz  = round_q14(s * x + c * z);
        ry  = round_q14(c * y - s * w);
        rw  = round_q14(s * y + c * w) + longint'(w_off);
        res.sx  = '0;
        res.sy  = '0;
        res.flt = FAULT_DENOM;
        if (rw <= 0)
            return res;
        x1 = sat_to(div_frac(rx, rw), MID_SAT, hit);
        y1 = sat_to(div_frac(ry, rw), MID_SAT, hit);
        z1 = sat_to(div_frac(rz, rw), MID_SAT, hit) + longint'(z_off);
        if (z1 <= 0)
            return res;
        res.sx  = COORD_W'(sat_to(div_frac(x1, z1), OUT_SAT, hit));
        res.sy  = COORD_W'(sat_to(div_frac(y1, z1), OUT_SAT, hit));
        res.flt = hit ? FAULT_SAT : FAULT_OK;
        return res;
    endfunction

    // track input, config and results on every edge
    always @(posedge clk or negedge rst_n)
    begin
        screen_pt_t exp_pt;
        if (!rst_n)
        begin
            angle_phase = '0;
            angle_step  = 16'd91;
            w_off       = 15'd8192;
            z_off       = 15'd24576;
            errors      = 0;
            screen_pts_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (screen_pts_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result x=%0d y=%0d fault=%0d",
                             $time, screen_x, screen_y, fault);
                end
                else
                begin
                    exp_pt = screen_pts_due.pop_front();
                    if (screen_x !== exp_pt.sx || screen_y !== exp_pt.sy
                        || fault !== exp_pt.flt)
                    begin
                        errors++;
                        $display("%0t: mismatch expected x=%0d y=%0d fault=%0d, got x=%0d y=%0d fault=%0d",
                                 $time, exp_pt.sx, exp_pt.sy, exp_pt.flt,
                                 screen_x, screen_y, fault);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (action == ACT_TICK)
                    angle_phase = angle_phase - angle_step;
                else
                    screen_pts_due.push_back(project_point(px, py, pz, pw, angle_phase));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ANGLE_STEP: angle_step = cfg_data;
                    CFG_W_OFFSET:   w_off = cfg_data[14:0];
                    CFG_Z_OFFSET:   z_off = cfg_data[14:0];
                    default: ;
                endcase
            end
        end
        pending = screen_pts_due.size();
    end

endmodule
`default_nettype wire

// ----- bench/rotate_project_4d_point_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module rotate_project_4d_point_tb;
    import rpp_pkg::*;

    localparam logic ACT_POINT = 1'b0;
    localparam logic ACT_TICK  = 1'b1;
    localparam int   IDLE_LIMIT = 20000;
    localparam int   DRAIN_WAIT = 300;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic action;
    logic signed [COORD_W-1:0] px, py, pz, pw;
    logic out_valid;
    logic out_ready;
    logic signed [COORD_W-1:0] screen_x, screen_y;
    logic [1:0] fault;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int   errors;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_req;
    int   quiet_cycles;

    rotate_project_4d_point i_dut (.*);

    rpp_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (3000) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic act, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [15:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        action   = act;
        px       = x;
        py       = y;
        pz       = z;
        pw       = w;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(8192)) - 4096);
            2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 30)
                send_item(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
            else
                send_item(ACT_POINT, rand_coord(), rand_coord(), rand_coord(),
                          rand_coord());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_POINT;
        px             = '0;
        py             = '0;
        pz             = '0;
        pw             = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ANGLE_STEP;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, field extremes, bad denominators, saturation
        send_item(ACT_POINT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_POINT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(ACT_POINT, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(ACT_POINT, 16'h1000, 16'hf000, 16'h0000, 16'h8000);
        send_item(ACT_POINT, 16'h8000, 16'h0000, 16'h8000, 16'he0c0);
        send_item(ACT_POINT, 16'h7fff, 16'h7fff, 16'ha240, 16'hf000);
        send_item(ACT_POINT, 16'h8000, 16'h7fff, 16'ha240, 16'hf000);
        send_item(ACT_TICK, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(ACT_POINT, 16'h7fff, 16'h8000, 16'h1234, 16'h0000);
        repeat (90) send_item(ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(ACT_POINT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(ACT_POINT, 16'h0400, 16'hfc00, 16'h0800, 16'h0100);
        drain();

        // zero offsets: every denominator at its lowest
        write_reg(CFG_ANGLE_STEP, 16'h0000);
        write_reg(CFG_W_OFFSET, 16'h0000);
        write_reg(CFG_Z_OFFSET, 16'h0000);
        send_item(ACT_POINT, 16'h0100, 16'h0100, 16'h0100, 16'h0100);
        send_item(ACT_POINT, 16'h7fff, 16'h8000, 16'h0001, 16'h0001);
        send_item(ACT_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_random(150);
        drain();

        // top offsets and step, sender mostly idle
        write_reg(CFG_ANGLE_STEP, 16'hffff);
        write_reg(CFG_W_OFFSET, 16'h7fff);
        write_reg(CFG_Z_OFFSET, 16'hffff);
        send_idle_pct = 79;
        send_random(180);
        drain();

        // random settings, receiver mostly stalled
        write_reg(CFG_ANGLE_STEP, 16'($urandom));
        write_reg(CFG_W_OFFSET, 16'($urandom_range(32767)));
        write_reg(CFG_Z_OFFSET, 16'($urandom_range(32767)));
        send_idle_pct  = 0;
        recv_stall_pct = 79;
        send_random(180);
        drain();

        // both sides idle at times; sender pauses until all results are back
        write_reg(CFG_ANGLE_STEP, 16'd4099);
        write_reg(CFG_W_OFFSET, 16'd4096);
        write_reg(CFG_Z_OFFSET, 16'd8192);
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        send_random(90);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        send_random(90);
        drain();

        // no idling, with one long receiver hold-off mid-stream
        write_reg(CFG_ANGLE_STEP, 16'($urandom));
        write_reg(CFG_W_OFFSET, 16'($urandom_range(32767)));
        write_reg(CFG_Z_OFFSET, 16'($urandom_range(32767)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(40);
        hold_req = 1'b1;
        send_random(150);

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
design/rpp_pkg.sv
design/rpp_front.sv
design/rpp_fifo.sv
design/rpp_div.sv
design/rpp_back.sv
design/rotate_project_4d_point.sv
bench/rpp_checker.sv
bench/rotate_project_4d_point_tb.sv
